// ===== rtl/bmd_pkg.sv =====
// Shared types, limits and level tables for the 2D block mode decoder.
package bmd_pkg;

  // Weight limits a legal block mode must meet
  localparam int unsigned MAX_WEIGHT_COUNT = 64;
  localparam int unsigned MIN_WEIGHT_BITS  = 24;
  localparam int unsigned MAX_WEIGHT_BITS  = 96;

  // Field widths
  localparam int unsigned MODE_W  = 11;
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned COUNT_W = 7;   // largest weight count is 120
  localparam int unsigned BITS_W  = 10;
  localparam int unsigned EXTRA_W = 9;   // largest trit/quint term is 280
  localparam int unsigned PROD_W  = 20;

  // Reciprocal multipliers: x*205>>10 == x/5 and x*683>>11 == x/3 for x < 1024
  localparam logic [7:0] RECIP5       = 8'd205;
  localparam int unsigned RECIP5_SH   = 10;
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int unsigned RECIP3_SH   = 11;

  // Encoding kind of a quantization level
  typedef enum logic [1:0] {
    KIND_BITS,
    KIND_TRIT,
    KIND_QUINT
  } level_kind_t;

  // Decoded header fields handed from the field decoder to the pipeline
  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic               dual;
    logic [LEVEL_W-1:0] level;
    logic               rsv;
  } mode_fields_t;

  // Plain bits per weight for a level
  function automatic logic [2:0] level_plain(input logic [LEVEL_W-1:0] lv);
    logic [2:0] r;
    case (lv)
      4'd0:    r = 3'd1;
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd0;
      4'd4:    r = 3'd1;
      4'd5:    r = 3'd3;
      4'd6:    r = 3'd1;
      4'd7:    r = 3'd2;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd2;
      4'd10:   r = 3'd3;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

  // Trit or quint packing for a level
  function automatic level_kind_t level_kind(input logic [LEVEL_W-1:0] lv);
    level_kind_t r;
    case (lv)
      4'd1, 4'd4, 4'd7, 4'd10: r = KIND_TRIT;
      4'd3, 4'd6, 4'd9:        r = KIND_QUINT;
      default:                 r = KIND_BITS;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bmd_field_decode.sv =====
// Combinational decode of the 11-bit block mode into grid size, planes and level.
module bmd_field_decode (
  input  logic [bmd_pkg::MODE_W-1:0] mode,
  output bmd_pkg::mode_fields_t      fields
);

  logic [2:0] prec;
  logic       hi;
  logic       dual;
  logic [1:0] a;
  logic [1:0] b;
  logic [3:0] w;
  logic [3:0] h;
  logic       rsv;

  // Grid layout selection
  always_comb begin
    hi   = mode[9];
    dual = mode[10];
    a    = mode[6:5];
    b    = mode[8:7];
    w    = 4'd0;
    h    = 4'd0;
    rsv  = 1'b0;
    prec = {mode[1:0], mode[4]};
    if (mode[1:0] != 2'b00) begin
      unique case (mode[3:2])
        2'd0: begin
          w = {2'b00, b} + 4'd4;
          h = {2'b00, a} + 4'd2;
        end
        2'd1: begin
          w = {2'b00, b} + 4'd8;
          h = {2'b00, a} + 4'd2;
        end
        2'd2: begin
          w = {2'b00, a} + 4'd2;
          h = {2'b00, b} + 4'd8;
        end
        default: begin
          if (mode[8]) begin
            w = {3'b000, mode[7]} + 4'd2;
            h = {2'b00, a} + 4'd2;
          end else begin
            w = {2'b00, a} + 4'd2;
            h = {3'b000, mode[7]} + 4'd6;
          end
        end
      endcase
    end else begin
      prec = {mode[3:2], mode[4]};
      if (mode[3:2] == 2'b00) begin
        rsv = 1'b1;
      end else begin
        unique case (mode[8:7])
          2'd0: begin
            w = 4'd12;
            h = {2'b00, a} + 4'd2;
          end
          2'd1: begin
            w = {2'b00, a} + 4'd2;
            h = 4'd12;
          end
          2'd2: begin
            // large grid: bits 10:9 size the rows
            w    = {2'b00, a} + 4'd6;
            h    = {2'b00, mode[10:9]} + 4'd6;
            dual = 1'b0;
            hi   = 1'b0;
          end
          default: begin
            if (a == 2'd0) begin
              w = 4'd6;
              h = 4'd10;
            end else if (a == 2'd1) begin
              w = 4'd10;
              h = 4'd6;
            end else begin
              rsv = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Reserved encodings report all fields zero, with only the rsv flag set
  always_comb begin
    fields.rsv = rsv;
    if (rsv) begin
      fields.width  = '0;
      fields.height = '0;
      fields.dual   = 1'b0;
      fields.level  = '0;
    end else begin
      fields.width  = w;
      fields.height = h;
      fields.dual   = dual;
      fields.level  = {1'b0, prec} - 4'd2 + (hi ? 4'd6 : 4'd0);
    end
  end

endmodule

// ===== rtl/block_mode_decode_2d_core.sv =====
// Top level: four-stage pipelined 2D block mode decoder with weight bit count.
// Stages, in order: decode, weight count, multiply, sum and limit check,
// each stage one register, the last one driving out_valid.
// Throughput: one transaction per cycle; each stage holds under backpressure
// and frees as soon as the stage after it moves.
// Reset: rst (synchronous) clears all stage valid bits; payload is not reset.
module block_mode_decode_2d_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bmd_pkg::MODE_W-1:0]  mode_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bmd_pkg::DIM_W-1:0]   grid_width,
  output logic [bmd_pkg::DIM_W-1:0]   grid_height,
  output logic                        two_planes,
  output logic [bmd_pkg::LEVEL_W-1:0] weight_level,
  output logic [bmd_pkg::BITS_W-1:0]  weight_bit_total,
  output logic                        mode_ok
);

  bmd_pkg::mode_fields_t dec;
  bmd_pkg::mode_fields_t f1;
  bmd_pkg::mode_fields_t f2;
  bmd_pkg::mode_fields_t f3;
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [7:0]                   wh;
  logic [8:0]                   cnt_full;
  logic [bmd_pkg::COUNT_W-1:0]  cnt2;
  logic [bmd_pkg::BITS_W-1:0]   plain3;
  logic [bmd_pkg::EXTRA_W-1:0]  extra3;
  logic                         cnt_ok3;
  logic [bmd_pkg::BITS_W-1:0]   plain_next;
  logic [bmd_pkg::EXTRA_W-1:0]  extra_next;
  logic [bmd_pkg::PROD_W-1:0]   trit_prod;
  logic [bmd_pkg::PROD_W-1:0]   quint_prod;
  logic [bmd_pkg::BITS_W-1:0]   bits_next;

  // Stage ready chain
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: header field decode
  bmd_field_decode u_decode (
    .mode   (mode_word),
    .fields (dec)
  );

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) f1 <= dec;
  end

  // Stage 2: weight count = width * height * planes
  assign wh       = {4'd0, f1.width} * {4'd0, f1.height};
  assign cnt_full = {1'b0, wh} << f1.dual;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      f2   <= f1;
      cnt2 <= cnt_full[bmd_pkg::COUNT_W-1:0];
    end
  end

  // Stage 3: plain bits product and trit/quint term by reciprocal multiply
  assign trit_prod  = {10'd0, {3'b000, cnt2} * 10'd8 + 10'd4} * {12'd0, bmd_pkg::RECIP5};
  assign quint_prod = {10'd0, {3'b000, cnt2} * 10'd7 + 10'd2} * {10'd0, bmd_pkg::RECIP3};
  assign plain_next = {3'b000, cnt2} * {7'd0, bmd_pkg::level_plain(f2.level)};

  always_comb begin
    case (bmd_pkg::level_kind(f2.level))
      bmd_pkg::KIND_TRIT:
        extra_next = trit_prod[bmd_pkg::RECIP5_SH +: bmd_pkg::EXTRA_W];
      bmd_pkg::KIND_QUINT:
        extra_next = quint_prod[bmd_pkg::RECIP3_SH +: bmd_pkg::EXTRA_W];
      default:
        extra_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      f3      <= f2;
      plain3  <= plain_next;
      extra3  <= extra_next;
      cnt_ok3 <= ({25'd0, cnt2} <= 32'(bmd_pkg::MAX_WEIGHT_COUNT));
    end
  end

  // Stage 4: total bits, limit check, output register
  assign bits_next = plain3 + {1'b0, extra3};

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      grid_width       <= f3.width;
      grid_height      <= f3.height;
      two_planes       <= f3.dual;
      weight_level     <= f3.level;
      weight_bit_total <= bits_next;
      mode_ok          <= !f3.rsv && cnt_ok3 &&
                          ({22'd0, bits_next} >= 32'(bmd_pkg::MIN_WEIGHT_BITS)) &&
                          ({22'd0, bits_next} <= 32'(bmd_pkg::MAX_WEIGHT_BITS));
    end
  end

  assign out_valid = v4;

endmodule
